/* hw/rtl/assert_macros.svh */
// assert_macros.svh: concurrent assertion macros for the voice unpacker RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/vpu_pkg.sv */
// vpu_pkg: types, constants and helper functions of the voice unpacker.
// No dependencies; used by the interfaces, vpu_decode and voice_param_unpacker.
`default_nettype none

package vpu_pkg;

  localparam int NumOps     = 6;
  localparam int OpPacked   = 17;
  localparam int OpParams   = 21;
  localparam int NumParams  = 155;
  localparam int MaxRes     = 3;

  // byte codes within one operator's packed block
  localparam int OpLastRate = 10;
  localparam int OpSens     = 11;
  localparam int OpDetByte  = 12;
  localparam int OpMod      = 13;
  localparam int OpLevel    = 14;
  localparam int OpFreq     = 15;

  // global byte positions and their first parameter indexes
  localparam int PosEgBase  = NumOps * OpPacked;
  localparam int PosEgLast  = 109;
  localparam int PosAlgo    = 110;
  localparam int PosFbk     = 111;
  localparam int PosLfoBase = 112;
  localparam int PosLfoLast = 115;
  localparam int PosLfoWave = 116;
  localparam int PosTrans   = 117;
  localparam int PosName    = 118;

  localparam int IdxEgBase  = NumOps * OpParams;
  localparam int IdxAlgo    = 134;
  localparam int IdxFbk     = 135;
  localparam int IdxLfoBase = 137;
  localparam int IdxLfoWave = 141;
  localparam int IdxTrans   = 144;
  localparam int IdxName    = 145;
  localparam int ParamLast  = NumParams - 1;

  localparam int LevelMax   = 99;

  typedef logic [7:0] byte_t;
  typedef logic [6:0] pos_t;
  typedef logic [7:0] pidx_t;
  typedef logic [6:0] pval_t;
  typedef logic [3:0] det_t;
  typedef logic [1:0] cnt_t;

  typedef struct packed {
    cnt_t                     cnt;
    pidx_t [MaxRes-1:0]       idx;
    pval_t [MaxRes-1:0]       val;
  } dec_t;

  // value above 99 becomes value*99/255 rounded down
  function automatic pval_t scale99(byte_t b);
    logic [6:0]  v;
    logic [13:0] prod;
    logic [15:0] q;
    v    = b[6:0];
    prod = 14'(v) * 14'(LevelMax);
    q    = 16'(prod) + 16'd1 + 16'(prod[13:8]);
    if (v <= 7'(LevelMax)) begin
      return v;
    end
    return q[14:8];
  endfunction

  function automatic logic is_det_pos(pos_t p);
    logic hit;
    hit = 1'b0;
    for (int j = 0; j < NumOps; j++) begin
      if (p == 7'(j * OpPacked + OpDetByte)) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/vpu_ifs.sv */
// vpu_ifs: valid/ready channel interfaces for packed bytes and parameters.
// Depends on vpu_pkg.
`default_nettype none

interface vpu_in_if;
  import vpu_pkg::*;
  logic  valid;
  logic  ready;
  byte_t packed_byte;
  logic  frame_start;
  modport source (output valid, packed_byte, frame_start, input ready);
  modport sink   (input valid, packed_byte, frame_start, output ready);
endinterface

interface vpu_out_if;
  import vpu_pkg::*;
  logic  valid;
  logic  ready;
  pidx_t param_index;
  pval_t param_value;
  logic  run_last;
  logic  voice_done;
  modport source (output valid, param_index, param_value, run_last, voice_done,
                  input ready);
  modport sink   (input valid, param_index, param_value, run_last, voice_done,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/vpu_decode.sv */
// vpu_decode: maps one packed byte at its record position to up to three
// parameters (index, value). Depends on vpu_pkg.
`default_nettype none

module vpu_decode (
  input  vpu_pkg::byte_t b,
  input  vpu_pkg::pos_t  p,
  input  vpu_pkg::det_t  det,
  output vpu_pkg::dec_t  dec
);
  import vpu_pkg::*;

  logic [2:0] op;
  logic [4:0] i;
  pidx_t      base;

  always_comb begin
    op = '0;
    for (int j = 1; j < NumOps; j++) begin
      if (p >= 7'(j * OpPacked)) begin
        op = 3'(j);
      end
    end
    i    = 5'(p - 7'(int'(op) * OpPacked));
    base = 8'(int'(op) * OpParams);
  end

  always_comb begin
    dec     = '0;
    dec.cnt = 2'd1;
    if (p < 7'(PosEgBase)) begin
      if (i <= 5'(OpLastRate)) begin
        dec.idx[0] = base + 8'(i);
        dec.val[0] = scale99(b);
      end else begin
        unique case (i)
          5'(OpSens): begin
            dec.cnt    = 2'd2;
            dec.idx[0] = base + 8'd11;
            dec.val[0] = 7'(b[1:0]);
            dec.idx[1] = base + 8'd12;
            dec.val[1] = 7'(b[3:2]);
          end
          5'(OpDetByte): begin
            dec.idx[0] = base + 8'd13;
            dec.val[0] = 7'(b[2:0]);
          end
          5'(OpMod): begin
            dec.cnt    = 2'd2;
            dec.idx[0] = base + 8'd14;
            dec.val[0] = 7'(b[1:0]);
            dec.idx[1] = base + 8'd15;
            dec.val[1] = 7'(b[4:2]);
          end
          5'(OpLevel): begin
            dec.idx[0] = base + 8'd16;
            dec.val[0] = b[6:0];
          end
          5'(OpFreq): begin
            dec.cnt    = 2'd2;
            dec.idx[0] = base + 8'd17;
            dec.val[0] = 7'(b[0]);
            dec.idx[1] = base + 8'd18;
            dec.val[1] = 7'(b[5:1]);
          end
          default: begin
            dec.cnt    = 2'd2;
            dec.idx[0] = base + 8'd19;
            dec.val[0] = b[6:0];
            dec.idx[1] = base + 8'd20;
            dec.val[1] = 7'(det);
          end
        endcase
      end
    end else begin
      priority if (p <= 7'(PosEgLast)) begin
        dec.idx[0] = 8'(p) + 8'(IdxEgBase - PosEgBase);
        dec.val[0] = scale99(b);
      end else if (p == 7'(PosAlgo)) begin
        dec.idx[0] = 8'(IdxAlgo);
        dec.val[0] = 7'(b[4:0]);
      end else if (p == 7'(PosFbk)) begin
        dec.cnt    = 2'd2;
        dec.idx[0] = 8'(IdxFbk);
        dec.val[0] = 7'(b[2:0]);
        dec.idx[1] = 8'(IdxFbk + 1);
        dec.val[1] = 7'(b[3]);
      end else if (p <= 7'(PosLfoLast)) begin
        dec.idx[0] = 8'(p) + 8'(IdxLfoBase - PosLfoBase);
        dec.val[0] = b[6:0];
      end else if (p == 7'(PosLfoWave)) begin
        dec.cnt    = 2'd3;
        dec.idx[0] = 8'(IdxLfoWave);
        dec.val[0] = 7'(b[0]);
        dec.idx[1] = 8'(IdxLfoWave + 1);
        dec.val[1] = 7'(b[3:1]);
        dec.idx[2] = 8'(IdxLfoWave + 2);
        dec.val[2] = 7'(b[6:4]);
      end else if (p == 7'(PosTrans)) begin
        dec.idx[0] = 8'(IdxTrans);
        dec.val[0] = b[6:0];
      end else begin
        dec.idx[0] = 8'(p) + 8'(IdxName - PosName);
        dec.val[0] = b[6:0];
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/voice_param_unpacker.sv */
// voice_param_unpacker: streams a 128-byte packed voice record into its
// 155 parameters. Depends on vpu_pkg, vpu_ifs, vpu_decode, assert_macros.svh.
//
//  channel | dir | word                                          | accepted when
//  in_ch   | in  | packed_byte, frame_start                      | valid && ready
//  out_ch  | out | param_index, param_value, run_last, voice_done | valid && ready
//
// One parameter leaves per cycle unless out_ch stalls; a byte stays in the
// unpack register until all its parameters (1 to 3) pass the single output port.
// A byte's first parameter is registered in the unpack, then the output register.
// The next byte is taken in the cycle its predecessor's last parameter moves on.
// Synchronous reset clears record position, held detune, sub-index and valid flags.
// out_ch.ready low with out_ch.valid high holds the output and unpack registers.
`default_nettype none
`include "assert_macros.svh"

module voice_param_unpacker (
  input wire logic  clk,
  input wire logic  rst_n,
  vpu_in_if.sink    in_ch,
  vpu_out_if.source out_ch
);
  import vpu_pkg::*;

  logic  in_vld_r;
  byte_t byte_r;
  pos_t  pos_r;
  det_t  det_r;
  pos_t  byte_pos_r;
  pos_t  byte_pos_nxt;
  det_t  held_det_r;
  det_t  held_det_nxt;
  cnt_t  k_r;

  logic  out_vld_r;
  pidx_t out_idx_r;
  pval_t out_val_r;
  logic  out_last_r;
  logic  out_done_r;

  dec_t  dec;
  pos_t  p_in;
  logic  in_acc;
  logic  emit;
  logic  emit_last;
  logic  is_last;

  vpu_decode u_decode (
    .b   (byte_r),
    .p   (pos_r),
    .det (det_r),
    .dec (dec)
  );

  assign p_in      = in_ch.frame_start ? '0 : byte_pos_r;
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign is_last   = (k_r == dec.cnt - 2'd1);
  assign emit      = in_vld_r && (!out_vld_r || out_ch.ready);
  assign emit_last = emit && is_last;

  assign in_ch.ready = !in_vld_r || emit_last;

  always_comb begin
    byte_pos_nxt = byte_pos_r;
    held_det_nxt = held_det_r;
    if (in_acc) begin
      byte_pos_nxt = p_in + 7'd1;
      if (is_det_pos(p_in)) begin
        held_det_nxt = in_ch.packed_byte[6:3];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      byte_pos_r <= '0;
      held_det_r <= '0;
      k_r        <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      byte_pos_r <= byte_pos_nxt;
      held_det_r <= held_det_nxt;
      if (in_acc) begin
        in_vld_r <= 1'b1;
      end else if (emit_last) begin
        in_vld_r <= 1'b0;
      end
      if (emit_last) begin
        k_r <= '0;
      end else if (emit) begin
        k_r <= k_r + 2'd1;
      end
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_r <= in_ch.packed_byte;
      pos_r  <= p_in;
      det_r  <= held_det_r;
    end
    if (emit) begin
      out_idx_r  <= dec.idx[k_r];
      out_val_r  <= dec.val[k_r];
      out_last_r <= is_last;
      out_done_r <= (dec.idx[k_r] == 8'(ParamLast));
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.param_index = out_idx_r;
  assign out_ch.param_value = out_val_r;
  assign out_ch.run_last    = out_last_r;
  assign out_ch.voice_done  = out_done_r;

  `ASSERT_IMPL(a_sub_in_range, in_vld_r, k_r < dec.cnt, "sub index past result count")
  `ASSERT_IMPL(a_done_is_last, out_vld_r && out_done_r, out_last_r,
               "final parameter not last of its byte")
  `ASSERT_NEXT(a_hold_partial, emit && !is_last, in_vld_r && k_r != '0,
               "byte dropped before all parameters left")
  `ASSERT_NEXT(a_accept_loads, in_acc, in_vld_r && k_r == '0,
               "accepted byte not loaded at first result")

endmodule

`default_nettype wire
